### src/cth_pkg.sv
// cth_pkg: shared constants, codes and types of the circular top-hat threshold block
`timescale 1ns / 1ps

package cth_pkg;

  // default build sizes
  localparam int MAX_WIDTH_DEF   = 1024;
  localparam int MAX_HEIGHT_DEF  = 1024;
  localparam int MAX_RADIUS_DEF  = 7;
  localparam int SAMPLE_BITS_DEF = 16;

  // configuration port
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 11;
  localparam int CFG_DIM_BITS   = 11;
  localparam int CFG_RAD_BITS   = 3;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_WIDTH   = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_WINDOW_RADIUS = 2'd2;

  localparam logic [CFG_DIM_BITS-1:0] RST_IMAGE_WIDTH   = 11'd1024;
  localparam logic [CFG_DIM_BITS-1:0] RST_IMAGE_HEIGHT  = 11'd1024;
  localparam logic [CFG_RAD_BITS-1:0] RST_WINDOW_RADIUS = 3'd3;

  // input item kinds
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  // window unit status toward the sequencer
  typedef struct packed {
    logic rd_en;
    logic done;
  } win_stat_t;

endpackage

### src/cth_line_bank.sv
// cth_line_bank: one row slot of the line store, one write and one registered read port
`timescale 1ns / 1ps

module cth_line_bank import cth_pkg::*; #(
  parameter int DEPTH     = MAX_WIDTH_DEF,
  parameter int DATA_BITS = SAMPLE_BITS_DEF,
  localparam int ADDR_BITS = $clog2(DEPTH)
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [ADDR_BITS-1:0] waddr_i,
  input  logic [DATA_BITS-1:0] wdata_i,
  input  logic                 re_i,
  input  logic [ADDR_BITS-1:0] raddr_i,
  output logic [DATA_BITS-1:0] rdata_o
);

  logic [DATA_BITS-1:0] mem [DEPTH];
  logic [DATA_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/cth_window.sv
// cth_window: column-by-column sweep of the circular window, masking and accumulation
`timescale 1ns / 1ps

module cth_window import cth_pkg::*; #(
  parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT  = MAX_HEIGHT_DEF,
  parameter int MAX_RADIUS  = MAX_RADIUS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int SLOTS     = 2 * MAX_RADIUS + 1,
  localparam int SLOT_BITS = $clog2(SLOTS),
  localparam int COL_BITS  = $clog2(MAX_WIDTH),
  localparam int DIM_BITS  = $clog2(MAX_WIDTH + 1),
  localparam int ROW_BITS  = $clog2(MAX_HEIGHT + 1),
  localparam int RAD_BITS  = $clog2(MAX_RADIUS + 1),
  localparam int CNT_BITS  = $clog2(SLOTS * SLOTS + 1),
  localparam int SUM_BITS  = SAMPLE_BITS - 1 + CNT_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [SLOT_BITS-1:0]          out_slot_i,
  input  logic [ROW_BITS-1:0]           out_row_i,
  input  logic [COL_BITS-1:0]           out_col_i,
  input  logic [DIM_BITS-1:0]           width_i,
  input  logic [ROW_BITS-1:0]           height_i,
  input  logic [RAD_BITS-1:0]           radius_i,
  output win_stat_t                     stat_o,
  output logic [COL_BITS-1:0]           rd_addr_o,
  input  logic signed [SAMPLE_BITS-1:0] rd_data_i [SLOTS],
  output logic [SUM_BITS-1:0]           sum_o,
  output logic [CNT_BITS-1:0]           cnt_o,
  output logic signed [SAMPLE_BITS-1:0] center_o
);

  localparam int SQ_BITS  = 2 * RAD_BITS + 1;
  localparam int GEO_BITS = (ROW_BITS > SLOT_BITS ? ROW_BITS : SLOT_BITS) + 2;
  localparam int XW       = (COL_BITS > RAD_BITS ? COL_BITS : RAD_BITS) + 2;

  typedef enum logic [1:0] {
    W_IDLE,
    W_SETUP,
    W_SWEEP,
    W_DRAIN
  } phase_e;

  phase_e                         phase_q;
  logic signed [RAD_BITS:0]       dx_q;
  logic [SQ_BITS-1:0]             rsq_q;
  logic [SLOTS-1:0]               row_ok_q;
  logic [SQ_BITS-1:0]             dysq_q [SLOTS];
  logic                           v1_q;
  logic                           col_ok1_q;
  logic [SQ_BITS-1:0]             dxsq1_q;
  logic                           ctr1_q;
  logic                           v2_q;
  logic [SAMPLE_BITS-2:0]         val2_q [SLOTS];
  logic [SLOTS-1:0]               take2_q;
  logic [SUM_BITS-1:0]            sum_q;
  logic [CNT_BITS-1:0]            cnt_q;
  logic signed [SAMPLE_BITS-1:0]  center_q;

  logic [SLOTS-1:0]               row_ok_d;
  logic [SQ_BITS-1:0]             dysq_d [SLOTS];
  logic [SLOTS-1:0]               take1;
  logic signed [XW-1:0]           x_pos;
  logic                           col_ok;
  logic signed [SQ_BITS:0]        dx_w;
  logic [SQ_BITS-1:0]             dxsq;
  logic signed [RAD_BITS:0]       r_s;
  logic [SUM_BITS-1:0]            col_sum;
  logic [CNT_BITS-1:0]            col_cnt;
  logic                           sweep_end;
  logic                           drained;

  assign r_s       = $signed({1'b0, radius_i});
  assign sweep_end = (dx_q == r_s);
  assign drained   = !v1_q && !v2_q;

  // column position of the current sweep step
  always_comb begin
    x_pos  = $signed(XW'(out_col_i)) + XW'(dx_q);
    col_ok = !x_pos[XW-1] && (x_pos < $signed(XW'(width_i)));
    dx_w   = (SQ_BITS + 1)'(dx_q);
    dxsq   = SQ_BITS'(dx_w * dx_w);
  end

  assign rd_addr_o    = x_pos[COL_BITS-1:0];
  assign stat_o.rd_en = (phase_q == W_SWEEP);
  assign stat_o.done  = (phase_q == W_DRAIN) && drained;

  for (genvar s = 0; s < SLOTS; s++) begin : g_lane
    logic signed [GEO_BITS-1:0] dlt;
    logic signed [GEO_BITS-1:0] dlt_w;
    logic signed [GEO_BITS-1:0] dy;
    logic signed [GEO_BITS-1:0] yrow;
    logic signed [GEO_BITS-1:0] rad_g;
    logic signed [SQ_BITS:0]    dy_w;
    logic [SQ_BITS:0]           dist_sq;

    // row offset of this slot relative to the center row
    always_comb begin
      dlt   = $signed(GEO_BITS'(s)) - $signed(GEO_BITS'(out_slot_i));
      dlt_w = (dlt < 0) ? dlt + $signed(GEO_BITS'(SLOTS)) : dlt;
      dy    = (dlt_w > $signed(GEO_BITS'(MAX_RADIUS))) ? dlt_w - $signed(GEO_BITS'(SLOTS))
                                                        : dlt_w;
      yrow  = $signed(GEO_BITS'(out_row_i)) + dy;
      rad_g = $signed(GEO_BITS'(radius_i));
      dy_w  = (SQ_BITS + 1)'(dy);
      row_ok_d[s] = (dy >= -rad_g) && (dy <= rad_g) && (yrow >= 0) &&
                    (yrow < $signed(GEO_BITS'(height_i)));
      dysq_d[s]   = SQ_BITS'(dy_w * dy_w);
    end

    always_comb begin
      dist_sq  = (SQ_BITS + 1)'(dxsq1_q) + (SQ_BITS + 1)'(dysq_q[s]);
      take1[s] = col_ok1_q && row_ok_q[s] && (dist_sq <= (SQ_BITS + 1)'(rsq_q)) &&
                 (rd_data_i[s] > 0);
    end
  end

  always_comb begin
    col_sum = '0;
    for (int s = 0; s < SLOTS; s++) begin
      col_sum = col_sum + SUM_BITS'(val2_q[s]);
    end
    col_cnt = CNT_BITS'($countones(take2_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= W_IDLE;
      dx_q      <= '0;
      rsq_q     <= '0;
      row_ok_q  <= '0;
      v1_q      <= 1'b0;
      col_ok1_q <= 1'b0;
      dxsq1_q   <= '0;
      ctr1_q    <= 1'b0;
      v2_q      <= 1'b0;
      take2_q   <= '0;
      sum_q     <= '0;
      cnt_q     <= '0;
      center_q  <= '0;
      for (int s = 0; s < SLOTS; s++) begin
        dysq_q[s] <= '0;
        val2_q[s] <= '0;
      end
    end else begin
      v1_q <= (phase_q == W_SWEEP);
      v2_q <= v1_q;

      unique case (phase_q)
        W_IDLE: begin
          if (start_i) begin
            phase_q <= W_SETUP;
          end
        end
        W_SETUP: begin
          row_ok_q <= row_ok_d;
          for (int s = 0; s < SLOTS; s++) begin
            dysq_q[s] <= dysq_d[s];
          end
          rsq_q   <= SQ_BITS'(radius_i) * SQ_BITS'(radius_i);
          dx_q    <= -r_s;
          sum_q   <= '0;
          cnt_q   <= '0;
          phase_q <= W_SWEEP;
        end
        W_SWEEP: begin
          col_ok1_q <= col_ok;
          dxsq1_q   <= dxsq;
          ctr1_q    <= (dx_q == '0);
          dx_q      <= dx_q + 1'b1;
          if (sweep_end) begin
            phase_q <= W_DRAIN;
          end
        end
        W_DRAIN: begin
          if (drained) begin
            phase_q <= W_IDLE;
          end
        end
      endcase

      // read data of the previous step: mask and register
      if (v1_q) begin
        take2_q <= take1;
        for (int s = 0; s < SLOTS; s++) begin
          val2_q[s] <= take1[s] ? rd_data_i[s][SAMPLE_BITS-2:0] : '0;
        end
        if (ctr1_q) begin
          center_q <= rd_data_i[out_slot_i];
        end
      end

      if (v2_q) begin
        sum_q <= sum_q + col_sum;
        cnt_q <= cnt_q + col_cnt;
      end
    end
  end

  assign sum_o    = sum_q;
  assign cnt_o    = cnt_q;
  assign center_o = center_q;

endmodule

### src/circular_tophat_threshold.sv
// circular_tophat_threshold: top level, sequencer, position counters and line store
//
// Raster-order pixels enter on the valid/ready input channel (kind_i = 0), flush ticks
// (kind_i = 1) after the last pixel drain the results still pending. Each pixel is stored
// in one of 2*MAX_RADIUS+1 line banks; once radius rows are buffered, every pixel transfer
// yields one result, for the pixel radius rows earlier. A flush tick yields one result only
// after the whole frame has arrived; end_of_frame_o marks the last result of the frame.
// From an item's transfer until its result is loaded, in_ready_o is low: the window unit
// reads one column of all line banks per cycle. Items that give no result leave in_ready_o
// high. The output register holds the result until out_ready_i; the next item is already
// accepted while it waits, and the block stalls only when a new result is ready and the
// previous one is still untaken.
// Configuration writes (index 0 width, 1 height, 2 radius) take effect at once and
// restart the frame; write them only while no item is in flight.
// Reset sets width 1024, height 1024, radius 3 and clears all position counters; the line
// store is not cleared and needs no clearing pass.
`timescale 1ns / 1ps

module circular_tophat_threshold import cth_pkg::*; #(
  parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT  = MAX_HEIGHT_DEF,
  parameter int MAX_RADIUS  = MAX_RADIUS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [CFG_INDEX_BITS-1:0]     cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0]      cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          kind_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          pixel_on_o,
  output logic                          end_of_frame_o
);

  localparam int SLOTS     = 2 * MAX_RADIUS + 1;
  localparam int SLOT_BITS = $clog2(SLOTS);
  localparam int COL_BITS  = $clog2(MAX_WIDTH);
  localparam int DIM_BITS  = $clog2(MAX_WIDTH + 1);
  localparam int ROW_BITS  = $clog2(MAX_HEIGHT + 1);
  localparam int RAD_BITS  = $clog2(MAX_RADIUS + 1);
  localparam int CNT_BITS  = $clog2(SLOTS * SLOTS + 1);
  localparam int SUM_BITS  = SAMPLE_BITS - 1 + CNT_BITS;
  localparam int PROD_BITS = SAMPLE_BITS + CNT_BITS + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WIN,
    ST_MUL,
    ST_OUT
  } state_e;

  state_e                         state_q;
  logic [CFG_DIM_BITS-1:0]        cfg_width_q;
  logic [CFG_DIM_BITS-1:0]        cfg_height_q;
  logic [CFG_RAD_BITS-1:0]        cfg_radius_q;
  logic [COL_BITS-1:0]            in_col_q;
  logic [ROW_BITS-1:0]            in_row_q;
  logic [SLOT_BITS-1:0]           in_slot_q;
  logic [COL_BITS-1:0]            out_col_q;
  logic [ROW_BITS-1:0]            out_row_q;
  logic [SLOT_BITS-1:0]           out_slot_q;
  logic                           out_valid_q;
  logic                           pixel_on_q;
  logic                           eof_q;
  logic signed [PROD_BITS-1:0]    prod_q;

  logic [DIM_BITS-1:0]            w_eff;
  logic [ROW_BITS-1:0]            h_eff;
  logic [RAD_BITS-1:0]            r_eff;
  logic                           cfg_hit;
  logic                           in_xfer;
  logic                           in_done;
  logic                           pix_write;
  logic                           go;
  logic                           in_last_col;
  logic                           out_last_col;
  logic                           out_last_row;
  logic                           out_free;
  win_stat_t                      win_stat;
  logic [COL_BITS-1:0]            rd_addr;
  logic signed [SAMPLE_BITS-1:0]  rd_data [SLOTS];
  logic [SUM_BITS-1:0]            win_sum;
  logic [CNT_BITS-1:0]            win_cnt;
  logic signed [SAMPLE_BITS-1:0]  win_center;

  // effective sizes after clamping
  always_comb begin
    if (cfg_width_q == '0) begin
      w_eff = DIM_BITS'(1);
    end else if (int'(cfg_width_q) > MAX_WIDTH) begin
      w_eff = DIM_BITS'(MAX_WIDTH);
    end else begin
      w_eff = DIM_BITS'(cfg_width_q);
    end
    if (cfg_height_q == '0) begin
      h_eff = ROW_BITS'(1);
    end else if (int'(cfg_height_q) > MAX_HEIGHT) begin
      h_eff = ROW_BITS'(MAX_HEIGHT);
    end else begin
      h_eff = ROW_BITS'(cfg_height_q);
    end
    if (int'(cfg_radius_q) > MAX_RADIUS) begin
      r_eff = RAD_BITS'(MAX_RADIUS);
    end else begin
      r_eff = RAD_BITS'(cfg_radius_q);
    end
  end

  assign cfg_hit = cfg_we_i && ((cfg_index_i == CFG_IMAGE_WIDTH) ||
                                (cfg_index_i == CFG_IMAGE_HEIGHT) ||
                                (cfg_index_i == CFG_WINDOW_RADIUS));

  assign in_ready_o   = (state_q == ST_IDLE);
  assign in_xfer      = in_valid_i && in_ready_o;
  assign in_done      = (in_row_q >= h_eff);
  assign pix_write    = in_xfer && (kind_i == KIND_PIXEL) && !in_done;
  assign go           = (kind_i == KIND_FLUSH) ? in_done
                                               : (!in_done && (in_row_q >= ROW_BITS'(r_eff)));
  assign in_last_col  = (DIM_BITS'(in_col_q) + DIM_BITS'(1)) == w_eff;
  assign out_last_col = (DIM_BITS'(out_col_q) + DIM_BITS'(1)) == w_eff;
  assign out_last_row = (out_row_q + ROW_BITS'(1)) == h_eff;
  assign out_free     = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= RST_IMAGE_WIDTH;
      cfg_height_q <= RST_IMAGE_HEIGHT;
      cfg_radius_q <= RST_WINDOW_RADIUS;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_IMAGE_WIDTH:   cfg_width_q  <= cfg_data_i[CFG_DIM_BITS-1:0];
        CFG_IMAGE_HEIGHT:  cfg_height_q <= cfg_data_i[CFG_DIM_BITS-1:0];
        CFG_WINDOW_RADIUS: cfg_radius_q <= cfg_data_i[CFG_RAD_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      in_col_q    <= '0;
      in_row_q    <= '0;
      in_slot_q   <= '0;
      out_col_q   <= '0;
      out_row_q   <= '0;
      out_slot_q  <= '0;
      out_valid_q <= 1'b0;
      pixel_on_q  <= 1'b0;
      eof_q       <= 1'b0;
      prod_q      <= '0;
    end else begin
      if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (pix_write) begin
            if (in_last_col) begin
              in_col_q  <= '0;
              in_row_q  <= in_row_q + 1'b1;
              in_slot_q <= (in_slot_q == SLOT_BITS'(SLOTS - 1)) ? '0 : in_slot_q + 1'b1;
            end else begin
              in_col_q <= in_col_q + 1'b1;
            end
          end
          if (in_xfer && go) begin
            state_q <= ST_WIN;
          end
        end
        ST_WIN: begin
          if (win_stat.done) begin
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod_q  <= win_center * $signed({1'b0, win_cnt});
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            pixel_on_q  <= (win_sum != '0) && (prod_q > $signed(PROD_BITS'(win_sum)));
            eof_q       <= out_last_row && out_last_col;
            if (out_last_row && out_last_col) begin
              in_col_q   <= '0;
              in_row_q   <= '0;
              in_slot_q  <= '0;
              out_col_q  <= '0;
              out_row_q  <= '0;
              out_slot_q <= '0;
            end else if (out_last_col) begin
              out_col_q  <= '0;
              out_row_q  <= out_row_q + 1'b1;
              out_slot_q <= (out_slot_q == SLOT_BITS'(SLOTS - 1)) ? '0 : out_slot_q + 1'b1;
            end else begin
              out_col_q <= out_col_q + 1'b1;
            end
            state_q <= ST_IDLE;
          end
        end
      endcase

      // a register write restarts the frame
      if (cfg_hit) begin
        in_col_q   <= '0;
        in_row_q   <= '0;
        in_slot_q  <= '0;
        out_col_q  <= '0;
        out_row_q  <= '0;
        out_slot_q <= '0;
      end
    end
  end

  for (genvar s = 0; s < SLOTS; s++) begin : g_bank
    logic [SAMPLE_BITS-1:0] bank_rdata;

    cth_line_bank #(
      .DEPTH     (MAX_WIDTH),
      .DATA_BITS (SAMPLE_BITS)
    ) u_bank (
      .clk_i   (clk_i),
      .we_i    (pix_write && (in_slot_q == SLOT_BITS'(s))),
      .waddr_i (in_col_q),
      .wdata_i (sample_i),
      .re_i    (win_stat.rd_en),
      .raddr_i (rd_addr),
      .rdata_o (bank_rdata)
    );

    assign rd_data[s] = $signed(bank_rdata);
  end

  cth_window #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_HEIGHT  (MAX_HEIGHT),
    .MAX_RADIUS  (MAX_RADIUS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_xfer && go),
    .out_slot_i (out_slot_q),
    .out_row_i  (out_row_q),
    .out_col_i  (out_col_q),
    .width_i    (w_eff),
    .height_i   (h_eff),
    .radius_i   (r_eff),
    .stat_o     (win_stat),
    .rd_addr_o  (rd_addr),
    .rd_data_i  (rd_data),
    .sum_o      (win_sum),
    .cnt_o      (win_cnt),
    .center_o   (win_center)
  );

  assign out_valid_o    = out_valid_q;
  assign pixel_on_o     = pixel_on_q;
  assign end_of_frame_o = eof_q;

endmodule
